@@ rtl/mkhp_pkg.sv @@
// ============================================================================
// mkhp_pkg
// Shared types and constants for the matrix kernel history propagator.
// ============================================================================
package mkhp_pkg;

  // Widths of the Q8.24 data path
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 24;

  // Command codes on the command port
  localparam logic [1:0] CMD_KWR  = 2'd0;
  localparam logic [1:0] CMD_HWR  = 2'd1;
  localparam logic [1:0] CMD_CLR  = 2'd2;
  localparam logic [1:0] CMD_STEP = 2'd3;

  // Operation after classification in the front end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_KWR,
    OP_HWR,
    OP_CLR,
    OP_STEP
  } op_e;

  // One queued command
  typedef struct packed {
    op_e                      op;
    logic [3:0]               tap;
    logic [1:0]               row;
    logic [1:0]               col;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } item_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WB
  } state_e;

  // Control travelling with each product term
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Finished element from the accumulator
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     sat;
  } res_t;

endpackage

@@ rtl/matrix_kernel_history_propagator_unit.sv @@
// ============================================================================
// matrix_kernel_history_propagator_unit
// Complex matrix-kernel history recurrence, Q8.24, one MAC unit.
// ============================================================================
// A step command runs taps_in_use * VEC_LEN * VEC_LEN complex
// multiply-accumulates, one per cycle through a single shared unit fed by
// the kernel and history memory read ports, then writes the new vector
// back into the history. Commands queue two deep; busy_o stays high while
// the queue is full. The VEC_LEN results of a step appear on done_o, each
// for a single cycle; the receiver cannot stall them. Write taps_in_use only
// while no command is pending or running.
module matrix_kernel_history_propagator_unit #(
  parameter int MAX_TAPS = 16,
  parameter int VEC_LEN  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [4:0]                         cfg_wdata_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         command_i,
  input  logic [3:0]                         tap_i,
  input  logic [1:0]                         row_i,
  input  logic [1:0]                         col_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] value_re_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] value_im_i,
  output logic                               done_o,
  output logic [1:0]                         element_o,
  output logic signed [mkhp_pkg::DATA_W-1:0] out_re_o,
  output logic signed [mkhp_pkg::DATA_W-1:0] out_im_o,
  output logic                               last_o,
  output logic [15:0]                        step_number_o,
  output logic                               saturated_o
);

  localparam int TCW = $clog2(MAX_TAPS + 1);

  logic [4:0]      taps_q;
  logic [TCW-1:0]  taps_eff;
  logic            pop, avail;
  mkhp_pkg::item_t item;

  // taps_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       taps_q <= 5'd16;
    else if (cfg_we_i) taps_q <= cfg_wdata_i;
  end

  // zero acts as one, oversize as the maximum
  always_comb begin
    priority if (taps_q == 5'd0)        taps_eff = TCW'(1);
    else if (32'(taps_q) > MAX_TAPS)    taps_eff = TCW'(MAX_TAPS);
    else                                taps_eff = TCW'(taps_q);
  end

  mkhp_front #(.MAX_TAPS(MAX_TAPS), .VEC_LEN(VEC_LEN)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .command_i  (command_i),
    .tap_i      (tap_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_re_i (value_re_i),
    .value_im_i (value_im_i),
    .busy_o     (busy_o),
    .pop_i      (pop),
    .avail_o    (avail),
    .item_o     (item)
  );

  mkhp_back #(.MAX_TAPS(MAX_TAPS), .VEC_LEN(VEC_LEN), .TCW(TCW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (avail),
    .item_i        (item),
    .pop_o         (pop),
    .taps_i        (taps_eff),
    .done_o        (done_o),
    .element_o     (element_o),
    .out_re_o      (out_re_o),
    .out_im_o      (out_im_o),
    .last_o        (last_o),
    .step_number_o (step_number_o),
    .saturated_o   (saturated_o)
  );

endmodule

@@ rtl/mkhp_front.sv @@
// ============================================================================
// mkhp_front
// Accepts commands, checks their indices and queues them for the back end.
// ============================================================================
module mkhp_front #(
  parameter int MAX_TAPS = 16,
  parameter int VEC_LEN  = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [1:0]                      command_i,
  input  logic [3:0]                      tap_i,
  input  logic [1:0]                      row_i,
  input  logic [1:0]                      col_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] value_re_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] value_im_i,
  output logic                            busy_o,
  input  logic                            pop_i,
  output logic                            avail_o,
  output mkhp_pkg::item_t                 item_o
);

  mkhp_pkg::item_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic            ok_k, ok_h;
  mkhp_pkg::op_e   op;

  // index checks
  assign ok_k = (32'(tap_i) < MAX_TAPS) && (32'(row_i) < VEC_LEN) && (32'(col_i) < VEC_LEN);
  assign ok_h = (32'(row_i) < VEC_LEN);

  // classify
  always_comb begin
    unique case (command_i)
      mkhp_pkg::CMD_KWR: op = ok_k ? mkhp_pkg::OP_KWR : mkhp_pkg::OP_NOP;
      mkhp_pkg::CMD_HWR: op = ok_h ? mkhp_pkg::OP_HWR : mkhp_pkg::OP_NOP;
      mkhp_pkg::CMD_CLR: op = mkhp_pkg::OP_CLR;
      default:           op = mkhp_pkg::OP_STEP;
    endcase
  end

  assign busy_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign push    = start_i && !busy_o;
  assign item_o  = slot_q[rd_ptr_q];

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op, tap: tap_i, row: row_i, col: col_i,
                            re: value_re_i, im: value_im_i};
    end
  end

endmodule

@@ rtl/mkhp_mac.sv @@
// ============================================================================
// mkhp_mac
// Complex multiply-accumulate with exact sum, rounding and saturation.
// ============================================================================
module mkhp_mac #(
  parameter int ACC_W = 75
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mkhp_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] k_re_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] k_im_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] h_re_i,
  input  logic signed [mkhp_pkg::DATA_W-1:0] h_im_i,
  output mkhp_pkg::res_t                     res_o
);

  localparam int PW = 2 * mkhp_pkg::DATA_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (mkhp_pkg::FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] MINV = ACC_W'(-64'sd2147483648);

  mkhp_pkg::mac_ctl_t      ctl2_q, ctl3_q;
  logic                    fin4_q;
  logic signed [PW-1:0]    p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW:0]      t_re_q, t_im_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0] sh_re, sh_im;
  logic                    hi_re, lo_re, hi_im, lo_im;
  logic                    res_vld_q;
  logic signed [mkhp_pkg::DATA_W-1:0] res_re_q, res_im_q;
  logic                    res_sat_q;

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q    <= '0;
      ctl3_q    <= '0;
      fin4_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      ctl2_q    <= ctl_i;
      ctl3_q    <= ctl2_q;
      fin4_q    <= ctl3_q.vld && ctl3_q.last;
      res_vld_q <= fin4_q;
    end
  end

  // products, term sums, accumulators
  always_ff @(posedge clk_i) begin
    p_rr_q <= k_re_i * h_re_i;
    p_ii_q <= k_im_i * h_im_i;
    p_ri_q <= k_re_i * h_im_i;
    p_ir_q <= k_im_i * h_re_i;
    t_re_q <= (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q);
    t_im_q <= (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q);
    if (ctl3_q.vld) begin
      acc_re_q <= ctl3_q.first ? ACC_W'(t_re_q) : acc_re_q + ACC_W'(t_re_q);
      acc_im_q <= ctl3_q.first ? ACC_W'(t_im_q) : acc_im_q + ACC_W'(t_im_q);
    end
  end

  // round half up, then clip
  always_comb begin
    sh_re = (acc_re_q + HALF) >>> mkhp_pkg::FRAC_BITS;
    sh_im = (acc_im_q + HALF) >>> mkhp_pkg::FRAC_BITS;
    hi_re = sh_re > MAXV;
    lo_re = sh_re < MINV;
    hi_im = sh_im > MAXV;
    lo_im = sh_im < MINV;
  end

  always_ff @(posedge clk_i) begin
    if (fin4_q) begin
      res_re_q  <= hi_re ? 32'sh7fffffff : lo_re ? 32'sh80000000 : sh_re[31:0];
      res_im_q  <= hi_im ? 32'sh7fffffff : lo_im ? 32'sh80000000 : sh_im[31:0];
      res_sat_q <= hi_re || lo_re || hi_im || lo_im;
    end
  end

  assign res_o = '{vld: res_vld_q, re: res_re_q, im: res_im_q, sat: res_sat_q};

endmodule

@@ rtl/mkhp_back.sv @@
// ============================================================================
// mkhp_back
// Executes queued commands: kernel and history stores, step sequencer.
// ============================================================================
module mkhp_back #(
  parameter int MAX_TAPS = 16,
  parameter int VEC_LEN  = 4,
  parameter int TCW      = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               avail_i,
  input  mkhp_pkg::item_t                    item_i,
  output logic                               pop_o,
  input  logic [TCW-1:0]                     taps_i,
  output logic                               done_o,
  output logic [1:0]                         element_o,
  output logic signed [mkhp_pkg::DATA_W-1:0] out_re_o,
  output logic signed [mkhp_pkg::DATA_W-1:0] out_im_o,
  output logic                               last_o,
  output logic [15:0]                        step_number_o,
  output logic                               saturated_o
);

  localparam int TIW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int VIW    = $clog2(VEC_LEN);
  localparam int KDEPTH = 2 ** (TIW + 2 * VIW);
  localparam int HDEPTH = 2 ** (TIW + VIW);
  localparam int ACC_W  = 2 * mkhp_pkg::DATA_W + 1 + $clog2(MAX_TAPS * VEC_LEN);
  localparam int WW     = 2 * mkhp_pkg::DATA_W;

  mkhp_pkg::state_e state_q, state_d;

  logic [VIW-1:0] i_q, j_q, wb_q, oel_q;
  logic [TIW-1:0] k_q, phys_q, head_q;
  logic [15:0]    step_cnt_q;
  logic           jlast, klast, ilast, wblast, oellast;

  logic [WW-1:0]  kmem [KDEPTH];
  logic [WW-1:0]  hmem [HDEPTH];
  logic           hvld_q [HDEPTH];
  logic [WW-1:0]  kd_q, hd_q;
  logic           hv_q;
  logic signed [mkhp_pkg::DATA_W-1:0] fresh_re_q [VEC_LEN];
  logic signed [mkhp_pkg::DATA_W-1:0] fresh_im_q [VEC_LEN];

  logic [TIW+2*VIW-1:0] kaddr, kwaddr;
  logic [TIW+VIW-1:0]   haddr, hwaddr;
  logic                 kwe, hwe, hclr;
  logic [WW-1:0]        hwdata;
  logic [TIW-1:0]       head_dec;

  mkhp_pkg::mac_ctl_t ctl_issue, ctl1_q;
  mkhp_pkg::res_t     res;
  logic signed [mkhp_pkg::DATA_W-1:0] h_re, h_im;

  assign jlast   = (j_q == VIW'(VEC_LEN - 1));
  assign ilast   = (i_q == VIW'(VEC_LEN - 1));
  assign wblast  = (wb_q == VIW'(VEC_LEN - 1));
  assign oellast = (oel_q == VIW'(VEC_LEN - 1));
  assign klast   = ((TCW'(k_q) + TCW'(1)) == taps_i);
  assign head_dec = (head_q == '0) ? TIW'(MAX_TAPS - 1) : head_q - TIW'(1);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mkhp_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and command decode
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    kwe       = 1'b0;
    hwe       = 1'b0;
    hclr      = 1'b0;
    hwaddr    = {head_q, VIW'(item_i.row)};
    hwdata    = {item_i.re, item_i.im};
    ctl_issue = '0;
    unique case (state_q)
      mkhp_pkg::ST_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          priority case (item_i.op)
            mkhp_pkg::OP_KWR:  kwe = 1'b1;
            mkhp_pkg::OP_HWR:  hwe = 1'b1;
            mkhp_pkg::OP_CLR:  hclr = 1'b1;
            mkhp_pkg::OP_STEP: state_d = mkhp_pkg::ST_RUN;
            default: ;
          endcase
        end
      end
      mkhp_pkg::ST_RUN: begin
        ctl_issue = '{vld: 1'b1, first: (k_q == '0) && (j_q == '0), last: klast && jlast};
        if (klast && jlast && ilast) state_d = mkhp_pkg::ST_DRAIN;
      end
      mkhp_pkg::ST_DRAIN: begin
        if (res.vld && oellast) state_d = mkhp_pkg::ST_WB;
      end
      mkhp_pkg::ST_WB: begin
        hwe    = 1'b1;
        hwaddr = {head_q, wb_q};
        hwdata = {fresh_re_q[wb_q], fresh_im_q[wb_q]};
        if (wblast) state_d = mkhp_pkg::ST_IDLE;
      end
      default: state_d = mkhp_pkg::ST_IDLE;
    endcase
  end

  // loop counters, ring head and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; j_q <= '0; k_q <= '0; wb_q <= '0; oel_q <= '0;
      phys_q <= '0; head_q <= '0; step_cnt_q <= '0;
    end else begin
      if (hclr) step_cnt_q <= '0;
      if (state_q == mkhp_pkg::ST_IDLE) begin
        i_q <= '0; j_q <= '0; k_q <= '0; wb_q <= '0; oel_q <= '0;
        phys_q <= head_q;
        if (pop_o && item_i.op == mkhp_pkg::OP_STEP) step_cnt_q <= step_cnt_q + 16'd1;
      end
      if (state_q == mkhp_pkg::ST_RUN) begin
        j_q <= jlast ? '0 : j_q + VIW'(1);
        if (jlast) begin
          if (klast) begin
            k_q    <= '0;
            phys_q <= head_q;
            i_q    <= i_q + VIW'(1);
          end else begin
            k_q    <= k_q + TIW'(1);
            phys_q <= (phys_q == TIW'(MAX_TAPS - 1)) ? '0 : phys_q + TIW'(1);
          end
        end
      end
      if (res.vld) oel_q <= oel_q + VIW'(1);
      if (state_q == mkhp_pkg::ST_DRAIN && state_d == mkhp_pkg::ST_WB) head_q <= head_dec;
      if (state_q == mkhp_pkg::ST_WB) wb_q <= wb_q + VIW'(1);
    end
  end

  // history valid bits: unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < HDEPTH; n++) hvld_q[n] <= 1'b0;
    end else if (hclr) begin
      for (int n = 0; n < HDEPTH; n++) hvld_q[n] <= 1'b0;
    end else if (hwe) begin
      hvld_q[hwaddr] <= 1'b1;
    end
  end

  assign kwaddr = {TIW'(item_i.tap), VIW'(item_i.row), VIW'(item_i.col)};
  assign kaddr  = {k_q, i_q, j_q};
  assign haddr  = {phys_q, j_q};

  // kernel and history memories, registered reads
  always_ff @(posedge clk_i) begin
    if (kwe) kmem[kwaddr] <= {item_i.re, item_i.im};
    if (hwe) hmem[hwaddr] <= hwdata;
    kd_q <= kmem[kaddr];
    hd_q <= hmem[haddr];
    hv_q <= hvld_q[haddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl1_q <= '0;
    else         ctl1_q <= ctl_issue;
  end

  assign h_re = hv_q ? hd_q[WW-1:mkhp_pkg::DATA_W] : '0;
  assign h_im = hv_q ? hd_q[mkhp_pkg::DATA_W-1:0]  : '0;

  mkhp_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl1_q),
    .k_re_i (kd_q[WW-1:mkhp_pkg::DATA_W]),
    .k_im_i (kd_q[mkhp_pkg::DATA_W-1:0]),
    .h_re_i (h_re),
    .h_im_i (h_im),
    .res_o  (res)
  );

  // new vector buffer for write-back
  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      fresh_re_q[oel_q] <= res.re;
      fresh_im_q[oel_q] <= res.im;
    end
  end

  assign done_o        = res.vld;
  assign element_o     = 2'(oel_q);
  assign out_re_o      = res.re;
  assign out_im_o      = res.im;
  assign last_o        = oellast;
  assign step_number_o = step_cnt_q;
  assign saturated_o   = res.sat;

endmodule

@@ rtl/mkhp_checker.sv @@
// ============================================================================
// mkhp_checker
// Port-level checks on the propagator, bound to the top level.
// ============================================================================
module mkhp_checker #(
  parameter int VEC_LEN = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       last_o,
  input logic [1:0] element_o
);

  // last marks the final element of a vector
  a_last_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (VEC_LEN > 4) || (last_o == (element_o == 2'(VEC_LEN - 1))))
    else $error("last flag does not match element index");

  // elements of a vector are never on adjacent cycles
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(done_o))
    else $error("results on consecutive cycles");

  // the queue fills only through an accepted command
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a command transfer");

endmodule

bind matrix_kernel_history_propagator_unit mkhp_checker #(.VEC_LEN(VEC_LEN)) u_mkhp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .last_o    (last_o),
  .element_o (element_o)
);

@@ tb/matrix_kernel_history_propagator_unit_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// matrix_kernel_history_propagator_unit_test
// Self-checking bench for the complex kernel history recurrence.
// Commands go through a queue-fed driver with random gaps. A monitor checks
// every element strobe against a bit-exact Q8.24 predictor. taps_in_use is
// swept over several settings, including 0 and values above MAX_TAPS.
// ============================================================================
module matrix_kernel_history_propagator_unit_test;

  localparam int NTAPS = 16;
  localparam int NVEC  = 4;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [1:0]        cmd;
    logic [3:0]        tap;
    logic [1:0]        row;
    logic [1:0]        col;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cmd_item_t;

  typedef struct {
    logic [1:0]         element;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
    logic [15:0]        step_no;
    logic               sat;
  } element_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [4:0]         cfg_wdata_i = 5'd16;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         command_i = mkhp_pkg::CMD_CLR;
  logic [3:0]         tap_i = '0;
  logic [1:0]         row_i = '0;
  logic [1:0]         col_i = '0;
  logic signed [31:0] value_re_i = '0;
  logic signed [31:0] value_im_i = '0;
  logic               done_o;
  logic [1:0]         element_o;
  logic signed [31:0] out_re_o;
  logic signed [31:0] out_im_o;
  logic               last_o;
  logic [15:0]        step_number_o;
  logic               saturated_o;

  matrix_kernel_history_propagator_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start_i, .busy_o,
    .command_i, .tap_i, .row_i, .col_i, .value_re_i, .value_im_i,
    .done_o, .element_o, .out_re_o, .out_im_o, .last_o, .step_number_o,
    .saturated_o
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic signed [31:0] kern_re [NTAPS*NVEC*NVEC];
  logic signed [31:0] kern_im [NTAPS*NVEC*NVEC];
  logic signed [31:0] hist_re [NTAPS*NVEC];
  logic signed [31:0] hist_im [NTAPS*NVEC];
  logic [15:0]        step_cnt = '0;
  logic [4:0]         taps_reg = 5'd16;
  bit                 kern_set [NTAPS*NVEC*NVEC];

  cmd_item_t pending_cmds[$];
  element_t  expected_elems[$];
  int        errors = 0;
  int        steps_taken = 0;
  int        elems_seen = 0;
  int        cfg_writes = 0;
  int        cycles = 0;
  bit        gaps_on = 1'b1;

  function automatic int taps_effective(logic [4:0] t);
    if (t == 0) return 1;
    if (t > NTAPS) return NTAPS;
    return int'(t);
  endfunction

  function automatic void saturate_q824(input logic signed [79:0] acc,
                                        output logic signed [31:0] val,
                                        inout logic clip);
    logic signed [79:0] r;
    r = (acc + 80'sd8388608) >>> 24;
    if (r > 80'sd2147483647) begin
      val = 32'sh7fffffff;
      clip = 1'b1;
    end else if (r < -80'sd2147483648) begin
      val = 32'sh80000000;
      clip = 1'b1;
    end else begin
      val = r[31:0];
    end
  endfunction

  // Apply one accepted command to the predictor
  task automatic propagate(input cmd_item_t c);
    logic signed [79:0] acc_re, acc_im;
    logic signed [31:0] new_re [NVEC];
    logic signed [31:0] new_im [NVEC];
    logic               clip [NVEC];
    int                 n, ki;
    element_t           e;
    case (c.cmd)
      mkhp_pkg::CMD_KWR: begin
        kern_re[(c.tap*NVEC + c.row)*NVEC + c.col] = c.re;
        kern_im[(c.tap*NVEC + c.row)*NVEC + c.col] = c.im;
      end
      mkhp_pkg::CMD_HWR: begin
        hist_re[c.row] = c.re;
        hist_im[c.row] = c.im;
      end
      mkhp_pkg::CMD_CLR: begin
        foreach (hist_re[i]) begin
          hist_re[i] = '0;
          hist_im[i] = '0;
        end
        step_cnt = '0;
      end
      default: begin
        n = taps_effective(taps_reg);
        for (int i = 0; i < NVEC; i++) begin
          acc_re = '0;
          acc_im = '0;
          clip[i] = 1'b0;
          for (int k = 0; k < n; k++) begin
            for (int j = 0; j < NVEC; j++) begin
              ki = (k*NVEC + i)*NVEC + j;
              acc_re = acc_re + kern_re[ki] * hist_re[k*NVEC + j]
                              - kern_im[ki] * hist_im[k*NVEC + j];
              acc_im = acc_im + kern_re[ki] * hist_im[k*NVEC + j]
                              + kern_im[ki] * hist_re[k*NVEC + j];
            end
          end
          saturate_q824(acc_re, new_re[i], clip[i]);
          saturate_q824(acc_im, new_im[i], clip[i]);
        end
        step_cnt = step_cnt + 16'd1;
        for (int x = NTAPS*NVEC - 1; x >= NVEC; x--) begin
          hist_re[x] = hist_re[x-NVEC];
          hist_im[x] = hist_im[x-NVEC];
        end
        for (int i = 0; i < NVEC; i++) begin
          hist_re[i] = new_re[i];
          hist_im[i] = new_im[i];
          e.element = 2'(i);
          e.re = new_re[i];
          e.im = new_im[i];
          e.last = (i == NVEC - 1);
          e.step_no = step_cnt;
          e.sat = clip[i];
          expected_elems.push_back(e);
        end
        steps_taken++;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: hands queued commands to the block, with random idle bursts
  int        gap_left = 0;
  cmd_item_t cur;
  always @(posedge clk_i) begin
    bit taken;
    taken = start_i && !busy_o;
    if (taken) propagate(cur);
    if (!start_i || taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur = pending_cmds.pop_front();
        command_i <= cur.cmd;
        tap_i <= cur.tap;
        row_i <= cur.row;
        col_i <= cur.col;
        value_re_i <= cur.re;
        value_im_i <= cur.im;
        start_i <= 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 19);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: each strobe is checked against the oldest expected element
  always @(posedge clk_i) begin
    element_t e;
    if (rst_ni && done_o) begin
      elems_seen++;
      if (expected_elems.size() == 0) begin
        report_mismatch("unexpected element", 32'(element_o), '0);
      end else begin
        e = expected_elems.pop_front();
        if (element_o !== e.element) report_mismatch("element", element_o, e.element);
        if (out_re_o !== e.re) report_mismatch("out_re", out_re_o, e.re);
        if (out_im_o !== e.im) report_mismatch("out_im", out_im_o, e.im);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        if (step_number_o !== e.step_no)
          report_mismatch("step_number", step_number_o, e.step_no);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  task automatic queue_cmd(input logic [1:0] cmd, input int tap, input int row,
                           input int col, input logic [31:0] re, input logic [31:0] im);
    cmd_item_t c;
    c.cmd = cmd;
    c.tap = 4'(tap);
    c.row = 2'(row);
    c.col = 2'(col);
    c.re = re;
    c.im = im;
    if (cmd == mkhp_pkg::CMD_KWR) kern_set[(tap*NVEC + row)*NVEC + col] = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // Mostly modest magnitudes so that the recurrence does not pin at the rails
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1, 2:    return {{10{1'b0}}, 22'($urandom)} - 32'h0020_0000;
      default: return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
    endcase
  endfunction

  // Kernel entries read by a step must already hold data
  task automatic fill_kernels(input int n);
    for (int k = 0; k < n; k++)
      for (int r = 0; r < NVEC; r++)
        for (int c = 0; c < NVEC; c++)
          if (!kern_set[(k*NVEC + r)*NVEC + c])
            queue_cmd(mkhp_pkg::CMD_KWR, k, r, c, rand_value(), rand_value());
  endtask

  task automatic queue_step();
    fill_kernels(taps_effective(taps_reg));
    queue_cmd(mkhp_pkg::CMD_STEP, $urandom_range(0, 15), $urandom_range(0, 3),
              $urandom_range(0, 3), $urandom, $urandom);
  endtask

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:
          queue_cmd(mkhp_pkg::CMD_KWR, $urandom_range(0, 15), $urandom_range(0, 3),
                    $urandom_range(0, 3), rand_value(), rand_value());
        3, 4:
          queue_cmd(mkhp_pkg::CMD_HWR, $urandom_range(0, 15), $urandom_range(0, 3),
                    $urandom_range(0, 3), rand_value(), rand_value());
        5:
          queue_cmd(mkhp_pkg::CMD_CLR, $urandom_range(0, 15), $urandom_range(0, 3),
                    $urandom_range(0, 3), $urandom, $urandom);
        default: queue_step();
      endcase
    end
  endtask

  // Wait for an idle block, then write taps_in_use
  task automatic set_taps(input logic [4:0] v);
    @(negedge clk_i);
    while (pending_cmds.size() > 0 || start_i || expected_elems.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    taps_reg = v;
    cfg_writes++;
  endtask

  // ---- main sequence ----
  initial begin
    logic [4:0] sweep [8] = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd5, 5'd1};
    foreach (hist_re[i]) begin
      hist_re[i] = '0;
      hist_im[i] = '0;
    end
    foreach (kern_re[i]) begin
      kern_re[i] = '0;
      kern_im[i] = '0;
      kern_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single tap, extreme values and every command
    set_taps(5'd1);
    queue_cmd(mkhp_pkg::CMD_KWR, 0, 0, 0, 32'h7fffffff, 32'h80000000);
    queue_cmd(mkhp_pkg::CMD_KWR, 0, 3, 3, 32'h80000000, 32'h7fffffff);
    queue_cmd(mkhp_pkg::CMD_KWR, 15, 3, 3, 32'h0100_0000, 32'hff00_0000);
    fill_kernels(1);
    queue_cmd(mkhp_pkg::CMD_HWR, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);
    queue_cmd(mkhp_pkg::CMD_HWR, 0, 3, 0, 32'h80000000, 32'h80000000);
    queue_cmd(mkhp_pkg::CMD_STEP, 0, 0, 0, '0, '0);
    queue_cmd(mkhp_pkg::CMD_STEP, 15, 3, 3, 32'hffffffff, 32'hffffffff);
    queue_cmd(mkhp_pkg::CMD_CLR, 15, 3, 3, 32'hffffffff, 32'hffffffff);
    queue_cmd(mkhp_pkg::CMD_STEP, 0, 0, 0, '0, '0);
    queue_cmd(mkhp_pkg::CMD_HWR, 0, 1, 0, 32'h0000_0001, 32'hffff_ffff);
    queue_cmd(mkhp_pkg::CMD_HWR, 0, 2, 0, 32'h0080_0000, 32'hff80_0000);
    queue_cmd(mkhp_pkg::CMD_STEP, 0, 0, 0, '0, '0);
    queue_cmd(mkhp_pkg::CMD_CLR, 0, 0, 0, '0, '0);
    queue_cmd(mkhp_pkg::CMD_HWR, 0, 0, 0, 32'h0100_0000, 32'h0000_0000);
    queue_step();
    queue_step();

    // Random phases over a sweep of tap counts; the last one runs gap-free
    foreach (sweep[p]) begin
      set_taps(sweep[p]);
      if (p == 7) gaps_on = 1'b0;
      queue_cmd(mkhp_pkg::CMD_CLR, 0, 0, 0, '0, '0);
      queue_random(10);
    end

    @(negedge clk_i);
    while (pending_cmds.size() > 0 || start_i || expected_elems.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d steps, %0d element transfers, %0d taps_in_use writes",
             steps_taken, elems_seen, cfg_writes);
    if (errors == 0 && expected_elems.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d elements outstanding", errors, expected_elems.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
